/* sv/cfa_pkg.sv */
// ----------------------------------------------------------------------------
// cfa_pkg: shared constants and types for the contiguous fit allocator
// Map size, command, status and policy codes, scan control struct.
// ----------------------------------------------------------------------------
package cfa_pkg;

	localparam int UNITS = 65536;
	localparam int UW    = $clog2(UNITS);     // unit index width
	localparam int CW    = UW + 1;            // count width, holds UNITS
	localparam int WW    = 32;                // map word width
	localparam int NW    = UNITS / WW;        // map words
	localparam int AW    = $clog2(NW);        // word address width
	localparam int BW    = $clog2(WW);        // bit in word width

	localparam logic [1:0] CMD_ALLOC   = 2'd0;
	localparam logic [1:0] CMD_COMPACT = 2'd1;
	localparam logic [1:0] CMD_LOAD    = 2'd2;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_NOFIT   = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_NEXT  = 2'd1;
	localparam logic [1:0] FIT_BEST  = 2'd2;
	localparam logic [1:0] FIT_WORST = 2'd3;

	// scan request from the sequencer to the run tracker
	typedef struct packed {
		logic          clear;   // restart run tracking
		logic          step;    // one unit is presented
		logic          used;    // that unit is used
		logic [UW-1:0] unit;    // that unit
		logic          close;   // end of map: close the open run
	} scan_ctl_t;

endpackage

/* sv/contiguous_fit_allocator.sv */
// ----------------------------------------------------------------------------
// contiguous_fit_allocator: bitmap allocator with first/next/best/worst fit
// Keeps a used map in a word memory and serves allocate, compact and load.
// ----------------------------------------------------------------------------
//  channel   | signals                                        | dir
//  in        | valid/ready, cmd request_size unit_index unit_used | in
//  out       | out_valid/out_ready, status start_unit failures | out
//  config    | cfg_we, cfg_wdata (fit_mode)                   | in
//
// Steps: load reads the word, writes it and outputs; allocate reads each 32-unit
// word scanned, then steps the tracker once per unit, over both passes for next
// fit, adds a pick step for best or worst fit, and reads then writes each word
// marked; compact reads and counts each map word, then fills every word.
// Reset: a clearing pass writes every map word to free, ready low.
// Stalls: the result waits in an output register; the next item is accepted
// only once the result is taken.
// ----------------------------------------------------------------------------
module contiguous_fit_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	input  logic        valid,
	output logic        ready,
	input  logic [1:0]  cmd,
	input  logic [16:0] request_size,
	input  logic [15:0] unit_index,
	input  logic        unit_used,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [15:0] start_unit,
	output logic [31:0] failures
);

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_RD    = 4'd2;   // issue word read
	localparam logic [3:0] S_BITS  = 4'd3;   // step bits of word
	localparam logic [3:0] S_DONE  = 4'd4;   // pass finished
	localparam logic [3:0] S_MARK  = 4'd5;   // read word to mark
	localparam logic [3:0] S_MARKW = 4'd6;
	localparam logic [3:0] S_LDW   = 4'd7;
	localparam logic [3:0] S_CNT   = 4'd8;   // compact: count used
	localparam logic [3:0] S_CNTW  = 4'd9;
	localparam logic [3:0] S_FILL  = 4'd10;
	localparam logic [3:0] S_OUT   = 4'd11;
	localparam logic [3:0] S_LDR   = 4'd12;
	localparam logic [3:0] S_PICK  = 4'd13;  // sized fit: read tracker pick

	localparam int UW = cfa_pkg::UW;
	localparam int CW = cfa_pkg::CW;
	localparam int AW = cfa_pkg::AW;
	localparam int BW = cfa_pkg::BW;
	localparam int WW = cfa_pkg::WW;

	logic [WW-1:0] mem [cfa_pkg::NW];
	logic [WW-1:0] rd_q;

	logic [3:0]    st_q;
	logic [1:0]    mode_q;
	logic [UW-1:0] rot_q;
	logic [31:0]   fail_q;
	logic [1:0]    cmd_q;
	logic [CW-1:0] size_q;
	logic [UW-1:0] idx_q;
	logic          val_q;
	logic [CW-1:0] pos_q;     // current unit, can reach UNITS
	logic [CW-1:0] end_q;     // pass end, exclusive
	logic          pass2_q;
	logic [CW-1:0] cnt_q;     // marks left / used count
	logic [UW-1:0] mpos_q;
	logic [AW-1:0] waddr_q;
	logic [1:0]    ost_q;
	logic [UW-1:0] ostart_q;
	logic          ovalid_q;

	cfa_pkg::scan_ctl_t ctl;
	logic          found;
	logic [UW-1:0] pick;
	logic [CW-1:0] pos_nx;
	logic          sized;
	logic          in_take;
	logic [WW-1:0] mark_mask;
	logic [WW-1:0] fill_word;
	logic [CW-1:0] word_base;
	logic [5:0]    pop;

	assign sized  = (mode_q == cfa_pkg::FIT_BEST) || (mode_q == cfa_pkg::FIT_WORST);
	assign pos_nx = pos_q + 1'b1;
	assign in_take = ready && valid;

	cfa_run_tracker u_trk (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .mode(mode_q), .size(size_q),
		.found(found), .pick_start(pick)
	);

	// drive the tracker from the sequencer
	always_comb begin
		ctl = '0;
		ctl.unit = pos_q[UW-1:0];
		ctl.used = rd_q[pos_q[BW-1:0]];
		if (in_take) ctl.clear = 1'b1;
		if (st_q == S_DONE && pass2_q == 1'b0 && mode_q == cfa_pkg::FIT_NEXT && !found)
			ctl.clear = 1'b1;
		if (st_q == S_BITS) ctl.step = 1'b1;
		if (st_q == S_DONE && sized) ctl.close = 1'b1;
	end

	// mask of run bits in the word being marked
	always_comb begin
		mark_mask = '0;
		for (int b = 0; b < WW; b++)
			if (BW'(b) >= mpos_q[BW-1:0] &&
			    CW'(b) < CW'(mpos_q[BW-1:0]) + cnt_q)
				mark_mask[b] = 1'b1;
	end

	// compact fill word: bits below used count set
	assign word_base = {1'b0, waddr_q, {BW{1'b0}}};
	always_comb begin
		for (int b = 0; b < WW; b++)
			fill_word[b] = (word_base + CW'(b)) < cnt_q;
	end
	assign pop = 6'($countones(rd_q));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_CLR;
			mode_q   <= cfa_pkg::FIT_FIRST;
			rot_q    <= '0;
			fail_q   <= '0;
			ovalid_q <= 1'b0;
			waddr_q  <= '0;
		end else begin
			if (cfg_we) mode_q <= cfg_wdata;
			if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			unique case (st_q)
				S_CLR: begin
					waddr_q <= waddr_q + 1'b1;
					if (waddr_q == '1) st_q <= S_IDLE;
				end
				S_IDLE: if (in_take) begin
					ost_q    <= cfa_pkg::ST_DONE;
					ostart_q <= '0;
					pass2_q  <= 1'b0;
					unique case (cmd)
						cfa_pkg::CMD_ALLOC: begin
							if (request_size == '0 || request_size > CW'(cfa_pkg::UNITS)) begin
								ost_q <= cfa_pkg::ST_INVALID;
								if (fail_q != '1) fail_q <= fail_q + 1'b1;
								st_q <= S_OUT;
							end else begin
								pos_q <= (mode_q == cfa_pkg::FIT_NEXT) ? CW'(rot_q) : '0;
								end_q <= CW'(cfa_pkg::UNITS);
								st_q  <= S_RD;
							end
						end
						cfa_pkg::CMD_COMPACT: begin
							waddr_q <= '0;
							cnt_q   <= '0;
							st_q    <= S_CNT;
						end
						cfa_pkg::CMD_LOAD: st_q <= S_LDR;
						default: st_q <= S_OUT;
					endcase
				end
				S_LDR: st_q <= S_LDW;
				S_LDW: st_q <= S_OUT;
				S_RD: begin
					if (pos_q >= end_q || (found && !sized)) st_q <= S_DONE;
					else st_q <= S_BITS;
				end
				S_BITS: begin
					pos_q <= pos_nx;
					if (pos_nx >= end_q || pos_nx[BW-1:0] == '0 || (found && !sized))
						st_q <= S_RD;
				end
				S_DONE: begin
					if (!found && mode_q == cfa_pkg::FIT_NEXT && !pass2_q) begin
						pass2_q <= 1'b1;
						pos_q   <= '0;
						end_q   <= CW'(rot_q);
						st_q    <= S_RD;
					end else if (sized) begin
						st_q <= S_PICK;    // tracker registers its pick at close
					end else if (found) begin
						mpos_q <= pick;
						cnt_q  <= size_q;
						st_q   <= S_MARK;
					end else begin
						ost_q <= cfa_pkg::ST_NOFIT;
						if (fail_q != '1) fail_q <= fail_q + 1'b1;
						st_q <= S_OUT;
					end
				end
				// sized fit resolves after tracker closes the last run
				S_PICK: begin
					if (found) begin
						mpos_q <= pick;
						cnt_q  <= size_q;
						st_q   <= S_MARK;
					end else begin
						ost_q <= cfa_pkg::ST_NOFIT;
						if (fail_q != '1) fail_q <= fail_q + 1'b1;
						st_q <= S_OUT;
					end
				end
				S_MARK: st_q <= S_MARKW;
				S_MARKW: begin
					if (CW'(mpos_q[BW-1:0]) + cnt_q <= CW'(WW)) begin
						ostart_q <= pick;
						if (mode_q == cfa_pkg::FIT_NEXT)
							rot_q <= UW'(pick + size_q[UW-1:0]);
						st_q <= S_OUT;
					end else begin
						cnt_q  <= cnt_q - CW'(WW - int'(mpos_q[BW-1:0]));
						mpos_q <= {mpos_q[UW-1:BW] + 1'b1, {BW{1'b0}}};
						st_q   <= S_MARK;
					end
				end
				S_CNT: st_q <= S_CNTW;
				S_CNTW: begin
					cnt_q   <= cnt_q + CW'(pop);
					waddr_q <= waddr_q + 1'b1;
					if (waddr_q == '1) st_q <= S_FILL;
					else st_q <= S_CNT;
				end
				S_FILL: begin
					waddr_q <= waddr_q + 1'b1;
					if (waddr_q == '1) st_q <= S_OUT;
				end
				// output register is empty here: items are taken only when it is
				S_OUT: begin
					ovalid_q <= 1'b1;
					st_q     <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// latch the item payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_q  <= cmd;
			size_q <= request_size;
			idx_q  <= unit_index;
			val_q  <= unit_used;
		end
	end

	// map memory: one read and one write port, registered read
	always_ff @(posedge clk) begin
		unique case (st_q)
			S_RD:   rd_q <= mem[pos_q[UW-1:BW]];
			S_MARK: rd_q <= mem[mpos_q[UW-1:BW]];
			S_LDR:  rd_q <= mem[idx_q[UW-1:BW]];
			S_CNT:  rd_q <= mem[waddr_q];
			default: ;
		endcase
		unique case (st_q)
			S_CLR:   mem[waddr_q] <= '0;
			S_MARKW: mem[mpos_q[UW-1:BW]] <= rd_q | mark_mask;
			S_LDW: if (cmd_q == cfa_pkg::CMD_LOAD) begin
				mem[idx_q[UW-1:BW]] <= val_q ? (rd_q | (WW'(1) << idx_q[BW-1:0]))
				                              : (rd_q & ~(WW'(1) << idx_q[BW-1:0]));
			end
			S_FILL:  mem[waddr_q] <= fill_word;
			default: ;
		endcase
	end

	assign ready      = (st_q == S_IDLE) && !ovalid_q;
	assign out_valid  = ovalid_q;
	assign status     = ost_q;
	assign start_unit = ostart_q;
	assign failures   = fail_q;

endmodule

/* sv/cfa_run_tracker.sv */
// ----------------------------------------------------------------------------
// cfa_run_tracker: free run counter and fit picker
// Counts the current free run unit by unit and keeps the chosen run.
// ----------------------------------------------------------------------------
module cfa_run_tracker (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfa_pkg::scan_ctl_t     ctl,
	input  logic [1:0]             mode,
	input  logic [cfa_pkg::CW-1:0] size,
	output logic                   found,
	output logic [cfa_pkg::UW-1:0] pick_start
);

	logic [cfa_pkg::CW-1:0] run_q;
	logic [cfa_pkg::UW-1:0] run_start_q;
	logic [cfa_pkg::CW-1:0] pick_len_q;
	logic                   found_q;
	logic [cfa_pkg::UW-1:0] pick_q;
	logic                   sized;
	logic                   take;
	logic [cfa_pkg::CW-1:0] run_nx;
	logic [cfa_pkg::UW-1:0] rs_nx;

	assign sized = (mode == cfa_pkg::FIT_BEST) || (mode == cfa_pkg::FIT_WORST);
	assign run_nx = run_q + 1'b1;
	assign rs_nx  = (run_q == '0) ? ctl.unit : run_start_q;

	// compare a closed run against the kept one
	always_comb begin
		take = 1'b0;
		if (run_q >= size && run_q != '0) begin
			if (!found_q) take = 1'b1;
			else if (mode == cfa_pkg::FIT_WORST) take = run_q > pick_len_q;
			else take = run_q < pick_len_q;
		end
	end

	// track runs, hold the chosen one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= '0;
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			run_q   <= '0;
			found_q <= 1'b0;
		end else if (ctl.close) begin
			if (sized && take) found_q <= 1'b1;
			run_q <= '0;
		end else if (ctl.step && !(found_q && !sized)) begin
			if (ctl.used) begin
				if (sized && take) found_q <= 1'b1;
				run_q <= '0;
			end else begin
				run_q <= run_nx;
				if (!sized && run_nx >= size) found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step && !ctl.used && !ctl.clear && !ctl.close) begin
			run_start_q <= rs_nx;
			if (!sized && !(found_q) && run_nx >= size) pick_q <= rs_nx;
		end
		if (sized && take && !ctl.clear && (ctl.close || (ctl.step && ctl.used))) begin
			pick_q     <= run_start_q;
			pick_len_q <= run_q;
		end
	end

	assign found      = found_q;
	assign pick_start = pick_q;

endmodule

/* sv/cfa_checker.sv */
// ----------------------------------------------------------------------------
// cfa_checker: port level checks for the allocator
// Watches handshakes and result fields over time.
// ----------------------------------------------------------------------------
module cfa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic        ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [15:0] start_unit,
	input logic [31:0] failures
);

	// status and failure count hold while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(failures))
		else $error("result changed while stalled");

	// start is zero unless done
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != cfa_pkg::ST_DONE |-> start_unit == '0)
		else $error("start without success");

	// failure count never falls between consecutive valid cycles
	a_mono: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && $past(out_valid) |-> failures >= $past(failures))
		else $error("failure count fell");

	// accepted item leaves ready low next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid && ready |=> !ready)
		else $error("ready stayed high after accept");

endmodule

bind contiguous_fit_allocator cfa_checker u_cfa_checker (
	.clk(clk), .arst_n(arst_n), .valid(valid), .ready(ready),
	.out_valid(out_valid), .out_ready(out_ready), .status(status),
	.start_unit(start_unit), .failures(failures)
);

/* sim/tb_contiguous_fit_allocator.sv */
// ----------------------------------------------------------------------------
// tb_contiguous_fit_allocator: self-checking bench for the fit allocator
// Drives load, allocate and compact items under all four placement policies,
// keeps its own copy of the used map, and checks every result in order.
// ----------------------------------------------------------------------------

// expected result of one item
typedef struct {
	logic [1:0]  status;
	logic [15:0] start_unit;
	logic [31:0] failures;
} alloc_result_t;

class alloc_scoreboard;
	bit            unit_map [cfa_pkg::UNITS];
	int unsigned   rotor;
	logic [31:0]   fail_total;
	logic [1:0]    policy;
	alloc_result_t pending [$];
	int            errors;

	function new();
		rotor      = 0;
		fail_total = 0;
		policy     = cfa_pkg::FIT_FIRST;
		errors     = 0;
	endfunction

	function void count_fail();
		if (fail_total != 32'hFFFF_FFFF)
			fail_total++;
	endfunction

	// start of the first free run in [lo, hi) whose count reaches want
	function bit find_first(int unsigned lo, int unsigned hi, int unsigned want,
			output int unsigned at);
		int unsigned run;
		int unsigned run_at;
		run    = 0;
		run_at = 0;
		at     = 0;
		for (int unsigned u = lo; u < hi; u++) begin
			if (unit_map[u]) begin
				run = 0;
			end else begin
				if (run == 0)
					run_at = u;
				run++;
				if (run >= want) begin
					at = run_at;
					return 1;
				end
			end
		end
		return 0;
	endfunction

	// smallest (or largest) whole free run that fits, lowest on ties
	function bit find_sized(int unsigned want, bit largest, output int unsigned at);
		int unsigned run;
		int unsigned run_at;
		int unsigned pick;
		bit          got;
		run  = 0;
		run_at = 0;
		pick = 0;
		got  = 0;
		at   = 0;
		for (int unsigned u = 0; u <= cfa_pkg::UNITS; u++) begin
			if (u < cfa_pkg::UNITS && !unit_map[u]) begin
				if (run == 0)
					run_at = u;
				run++;
			end else begin
				if (run >= want && run > 0 &&
						(!got || (largest ? run > pick : run < pick))) begin
					got  = 1;
					pick = run;
					at   = run_at;
				end
				run = 0;
			end
		end
		return got;
	endfunction

	// predict the result of an accepted item
	function void note_item(logic [1:0] op, logic [16:0] size, logic [15:0] idx,
			logic val);
		alloc_result_t r;
		int unsigned   at;
		int unsigned   n;
		bit            ok;
		r.status     = cfa_pkg::ST_DONE;
		r.start_unit = '0;
		case (op)
			cfa_pkg::CMD_ALLOC: begin
				if (size == 0 || size > cfa_pkg::UNITS) begin
					r.status = cfa_pkg::ST_INVALID;
					count_fail();
				end else begin
					if (policy == cfa_pkg::FIT_FIRST) begin
						ok = find_first(0, cfa_pkg::UNITS, size, at);
					end else if (policy == cfa_pkg::FIT_NEXT) begin
						ok = find_first(rotor, cfa_pkg::UNITS, size, at);
						if (!ok)
							ok = find_first(0, rotor, size, at);
					end else begin
						ok = find_sized(size, policy == cfa_pkg::FIT_WORST, at);
					end
					if (ok) begin
						for (int unsigned k = 0; k < size; k++)
							unit_map[at + k] = 1;
						if (policy == cfa_pkg::FIT_NEXT)
							rotor = (at + size) % cfa_pkg::UNITS;
						r.start_unit = at[15:0];
					end else begin
						r.status = cfa_pkg::ST_NOFIT;
						count_fail();
					end
				end
			end
			cfa_pkg::CMD_COMPACT: begin
				n = 0;
				foreach (unit_map[u])
					n += unit_map[u];
				foreach (unit_map[u])
					unit_map[u] = (u < n);
			end
			cfa_pkg::CMD_LOAD: begin
				unit_map[idx] = val;
			end
			default: ;
		endcase
		r.failures = fail_total;
		pending.push_back(r);
	endfunction

	task report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0d, expected %0d", what, got, want);
		errors++;
	endtask

	// compare one accepted result with the oldest prediction
	task check_result(logic [1:0] st, logic [15:0] su, logic [31:0] fl);
		alloc_result_t e;
		if (pending.size() == 0) begin
			report("unexpected result", 1, 0);
			return;
		end
		e = pending.pop_front();
		if (st !== e.status)
			report("status", st, e.status);
		if (su !== e.start_unit)
			report("start_unit", su, e.start_unit);
		if (fl !== e.failures)
			report("failures", fl, e.failures);
	endtask
endclass

module tb_contiguous_fit_allocator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 1500000;
	localparam logic [1:0] CMD_UNUSED = 2'd3;   // command with no effect

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_wdata;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [16:0] request_size;
	logic [15:0] unit_index;
	logic        unit_used;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [15:0] start_unit;
	logic [31:0] failures;

	alloc_scoreboard sb = new();

	int send_idle_pct = 10;
	int recv_idle_pct = 58;
	bit hold_request  = 0;
	int hold_left     = 0;
	int quiet_cycles  = 0;

	contiguous_fit_allocator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.valid        (valid),
		.ready        (ready),
		.cmd          (cmd),
		.request_size (request_size),
		.unit_index   (unit_index),
		.unit_used    (unit_used),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.start_unit   (start_unit),
		.failures     (failures)
	);

	initial clk = 0;
	always #6 clk = ~clk;

	// take results, stall at random, hold off for a long stretch on request
	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_result(status, start_unit, failures);
		if (hold_request && hold_left == 0)
			hold_left <= 6000;
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			if (hold_left == 1)
				hold_request <= 0;
			out_ready <= 0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((valid && ready) || (out_valid && out_ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// offer one item and hold it until accepted
	task automatic send_item(logic [1:0] op, logic [16:0] size, logic [15:0] idx,
			logic val);
		int gap;
		if ($urandom_range(99) < send_idle_pct) begin
			gap = $urandom_range(1, 6);
			valid <= 0;
			repeat (gap) @(posedge clk);
		end
		valid        <= 1;
		cmd          <= op;
		request_size <= size;
		unit_index   <= idx;
		unit_used    <= val;
		@(posedge clk);
		while (!ready)
			@(posedge clk);
		sb.note_item(op, size, idx, val);
	endtask

	// drain, then write the policy while the block is idle
	task automatic set_policy(logic [1:0] mode);
		valid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_we    <= 0;
		sb.policy = mode;
	endtask

	task automatic random_item();
		int pick;
		logic [16:0] size;
		pick = $urandom_range(99);
		if (pick < 35) begin
			send_item(cfa_pkg::CMD_LOAD, 17'($urandom), 16'($urandom), 1'($urandom));
		end else if (pick < 82) begin
			if ($urandom_range(9) < 7)
				size = 17'($urandom_range(1, 48));
			else if ($urandom_range(2) == 0)
				size = 17'($urandom_range(1, 70000));
			else
				size = 17'($urandom);
			send_item(cfa_pkg::CMD_ALLOC, size, 16'($urandom), 1'($urandom));
		end else if (pick < 94) begin
			send_item(cfa_pkg::CMD_COMPACT, 17'($urandom), 16'($urandom), 1'($urandom));
		end else begin
			send_item(CMD_UNUSED, 17'($urandom), 16'($urandom), 1'($urandom));
		end
	endtask

	initial begin
		arst_n       = 0;
		cfg_we       = 0;
		cfg_wdata    = cfa_pkg::FIT_FIRST;
		valid        = 0;
		cmd          = cfa_pkg::CMD_LOAD;
		request_size = '0;
		unit_index   = '0;
		unit_used    = 0;
		out_ready    = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		set_policy(cfa_pkg::FIT_FIRST);

		// directed: invalid sizes, edge units, no fit, compact, unknown command
		send_item(cfa_pkg::CMD_ALLOC, 17'd0, 16'd0, 1'b0);
		send_item(cfa_pkg::CMD_ALLOC, 17'd65537, 16'd0, 1'b0);
		send_item(cfa_pkg::CMD_ALLOC, 17'h1FFFF, 16'hFFFF, 1'b1);
		send_item(cfa_pkg::CMD_LOAD, 17'd0, 16'd100, 1'b1);
		send_item(cfa_pkg::CMD_LOAD, 17'd0, 16'd65535, 1'b1);
		send_item(cfa_pkg::CMD_ALLOC, 17'd65536, 16'd0, 1'b0);
		send_item(cfa_pkg::CMD_ALLOC, 17'd65435, 16'd0, 1'b0);
		send_item(cfa_pkg::CMD_LOAD, 17'd0, 16'd65535, 1'b0);
		send_item(cfa_pkg::CMD_ALLOC, 17'd1, 16'd0, 1'b0);
		send_item(cfa_pkg::CMD_ALLOC, 17'd5, 16'd0, 1'b0);
		send_item(cfa_pkg::CMD_LOAD, 17'd0, 16'd2, 1'b0);
		send_item(cfa_pkg::CMD_COMPACT, 17'd0, 16'd0, 1'b0);
		send_item(CMD_UNUSED, 17'd7, 16'd9, 1'b1);

		// next fit wraps around the pointer
		set_policy(cfa_pkg::FIT_NEXT);
		send_item(cfa_pkg::CMD_LOAD, 17'd0, 16'd40, 1'b1);
		send_item(cfa_pkg::CMD_ALLOC, 17'd20, 16'd0, 1'b0);
		send_item(cfa_pkg::CMD_ALLOC, 17'd3, 16'd0, 1'b0);
		send_item(cfa_pkg::CMD_LOAD, 17'd0, 16'd100, 1'b1);

		// best and worst fit over uneven holes
		set_policy(cfa_pkg::FIT_BEST);
		send_item(cfa_pkg::CMD_ALLOC, 17'd2, 16'd0, 1'b0);
		set_policy(cfa_pkg::FIT_WORST);
		send_item(cfa_pkg::CMD_ALLOC, 17'd2, 16'd0, 1'b0);

		// random phases cycling the four policies; idle schedules swap at phase 2, drop at 4
		for (int ph = 0; ph < 6; ph++) begin
			set_policy(2'(ph));
			if (ph == 2) begin
				send_idle_pct = 58;
				recv_idle_pct = 10;
			end else if (ph == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int i = 0; i < 14; i++) begin
				if (ph == 1 && i == 4)
					hold_request = 1;
				random_item();
			end
		end

		valid <= 0;
		while (sb.pending.size() != 0) begin
			@(posedge clk);
		end
		repeat (50) @(posedge clk);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

/* filelist.f */
sv/cfa_pkg.sv
sv/cfa_run_tracker.sv
sv/contiguous_fit_allocator.sv
sv/cfa_checker.sv
sim/tb_contiguous_fit_allocator.sv
